// ===== rtl/ivalc_pkg.sv =====
`default_nettype none

package ivalc_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int NUM_VECTORS_DEF         = 64;
    localparam int HANDLERS_PER_VECTOR_DEF = 32;
    localparam int HANDLER_ID_BITS_DEF     = 16;

    // Fixed field widths of the streams
    localparam int MODE_W      = 2;
    localparam int VEC_IN_W    = 8;
    localparam int VEC_W       = 7;
    localparam int STATUS_W    = 3;
    localparam int HID_FIELD_W = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Request kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIG  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd4;

    // Outcome of the free vector search
    typedef struct packed {
        logic             found;
        logic [VEC_W-1:0] idx;
    } t_search_res;

endpackage

`default_nettype wire

// ===== rtl/interrupt_vector_allocator_top.sv =====
// A request is taken only in idle, where its fields are captured and the count memory is read.
// Once the output is free, the execute state registers the result on the output or, for a trigger
// with handlers, issues the first handler memory read; the trigger state then gives one handler per cycle
// while the output is not stalled. No new request is taken until the result or last handler is emitted.
// Reset: control state and the occupancy flags clear at once; the count and handler memories
// need no clearing pass, as only entries written since allocation are ever read.
`default_nettype none

module interrupt_vector_allocator_top #(
    parameter int NUM_VECTORS         = ivalc_pkg::NUM_VECTORS_DEF,
    parameter int HANDLERS_PER_VECTOR = ivalc_pkg::HANDLERS_PER_VECTOR_DEF,
    parameter int HANDLER_ID_BITS     = ivalc_pkg::HANDLER_ID_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave side
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [ivalc_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // vector[7:0], handler_id[23:8]
    input  wire logic [ivalc_pkg::MODE_W-1:0]       i_s_tuser,  // mode[1:0]
    // master side
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic      [ivalc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,  // status[2:0], vector_out[9:3],
                                                                // handler_out[25:10], zero pad
    output logic                                    o_m_tuser,  // has_handler[0]
    output logic                                    o_m_tlast
);
    import ivalc_pkg::*;

    localparam int VIDX_W  = $clog2(NUM_VECTORS);
    localparam int CNT_W   = $clog2(HANDLERS_PER_VECTOR + 1);
    localparam int TBL_D   = NUM_VECTORS * HANDLERS_PER_VECTOR;
    localparam int TA_W    = $clog2(TBL_D);
    localparam int HID_W   = (HANDLER_ID_BITS < HID_FIELD_W) ? HANDLER_ID_BITS : HID_FIELD_W;
    localparam int PAD_W   = OUT_TDATA_W - STATUS_W - VEC_W - HID_FIELD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_TRIG = 2'd2;

    // Registers
    logic [1:0]             r_state, n_state;
    logic [MODE_W-1:0]      r_mode;
    logic                   r_inr;
    logic [VIDX_W-1:0]      r_vidx;
    logic [TA_W-1:0]        r_base;
    logic [HID_W-1:0]       r_hid;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [NUM_VECTORS-1:0] r_occ, n_occ;
    logic                   r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [VEC_W-1:0]       r_vec;
    logic [HID_FIELD_W-1:0] r_hout;
    logic                   r_has;
    logic                   r_last;

    // Input decode
    logic                   accept;
    logic [VEC_IN_W-1:0]    in_vec;
    logic                   in_inr;
    logic [VIDX_W-1:0]      in_vidx;

    // Memory ports
    logic [CNT_W-1:0]       cnt_rd;
    logic                   cnt_we;
    logic [VIDX_W-1:0]      cnt_waddr;
    logic [CNT_W-1:0]       cnt_wdata;
    logic [HID_W-1:0]       tbl_rd;
    logic                   tbl_we;
    logic                   tbl_re;
    logic [CNT_W-1:0]       tbl_ridx;

    // Sequencer outputs
    t_search_res            srch;
    logic                   out_free;
    logic                   emit;
    logic                   occ_set;
    logic [VIDX_W-1:0]      occ_idx;
    logic [STATUS_W-1:0]    e_status;
    logic [VEC_W-1:0]       e_vec;
    logic [HID_FIELD_W-1:0] e_hout;
    logic                   e_has;
    logic                   e_last;

    assign accept  = i_s_tvalid && o_s_tready;
    assign in_vec  = i_s_tdata[VEC_IN_W-1:0];
    assign in_inr  = !in_vec[VEC_IN_W-1] && (in_vec[VEC_W-1:0] < VEC_W'(NUM_VECTORS));
    assign in_vidx = in_inr ? in_vec[VIDX_W-1:0] : '0;

    // Per-vector handler counts
    ivalc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_VECTORS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (accept),
        .i_raddr (in_vidx),
        .o_rdata (cnt_rd)
    );

    // Handler lists, one row of HANDLERS_PER_VECTOR entries per vector
    ivalc_ram #(
        .WIDTH (HID_W),
        .DEPTH (TBL_D)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_base + TA_W'(cnt_rd)),
        .i_wdata (r_hid),
        .i_re    (tbl_re),
        .i_raddr (r_base + TA_W'(tbl_ridx)),
        .o_rdata (tbl_rd)
    );

    // Rotating first-free search over the occupancy flags
    ivalc_search #(
        .NUM_VECTORS (NUM_VECTORS)
    ) u_search (
        .i_occ  (r_occ),
        .i_hint (r_vidx),
        .o_res  (srch)
    );

    assign out_free = !r_out_valid || i_m_tready;

    // Request sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        emit      = 1'b0;
        occ_set   = 1'b0;
        occ_idx   = r_vidx;
        cnt_we    = 1'b0;
        cnt_waddr = r_vidx;
        cnt_wdata = '0;
        tbl_we    = 1'b0;
        tbl_re    = 1'b0;
        tbl_ridx  = '0;
        e_status  = ST_OK;
        e_vec     = VEC_W'(r_vidx);
        e_hout    = '0;
        e_has     = 1'b0;
        e_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_s_tuser != MODE_NONE)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    case (r_mode)
                        MODE_ALLOC: begin
                            if (srch.found) begin
                                occ_set   = 1'b1;
                                occ_idx   = srch.idx[VIDX_W-1:0];
                                cnt_we    = 1'b1;
                                cnt_waddr = srch.idx[VIDX_W-1:0];
                                e_vec     = srch.idx;
                            end else begin
                                e_status = ST_NO_FREE;
                                e_vec    = '0;
                            end
                        end
                        MODE_BIND: begin
                            if (!r_inr) begin
                                e_status = ST_RANGE;
                                e_vec    = '0;
                            end else if (!r_occ[r_vidx]) begin
                                e_status = ST_NOT_ALLOC;
                            end else if (cnt_rd >= CNT_W'(HANDLERS_PER_VECTOR)) begin
                                e_status = ST_FULL;
                            end else begin
                                tbl_we    = 1'b1;
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_rd + CNT_W'(1);
                            end
                        end
                        MODE_TRIG: begin
                            if (!r_inr) begin
                                e_status = ST_RANGE;
                                e_vec    = '0;
                            end else if (!r_occ[r_vidx]) begin
                                e_status = ST_NOT_ALLOC;
                            end else if (cnt_rd != '0) begin
                                // start streaming the list from its first entry
                                emit     = 1'b0;
                                tbl_re   = 1'b1;
                                tbl_ridx = '0;
                                n_idx    = '0;
                                n_state  = S_TRIG;
                            end
                        end
                        default: begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_TRIG: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_hout = HID_FIELD_W'(tbl_rd);
                    e_has  = 1'b1;
                    e_last = ((r_idx + CNT_W'(1)) == cnt_rd);
                    if (e_last) begin
                        n_state = S_IDLE;
                    end else begin
                        tbl_re   = 1'b1;
                        tbl_ridx = r_idx + CNT_W'(1);
                        n_idx    = r_idx + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Occupancy flags and output valid
    always_comb begin
        n_occ = r_occ;
        if (occ_set) begin
            n_occ[occ_idx] = 1'b1;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Request capture, list index and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_s_tuser;
            r_inr  <= in_inr;
            r_vidx <= in_vidx;
            r_base <= TA_W'(in_vidx) * TA_W'(HANDLERS_PER_VECTOR);
            r_hid  <= i_s_tdata[VEC_IN_W +: HID_W];
        end
        r_idx <= n_idx;
        if (emit) begin
            r_status <= e_status;
            r_vec    <= e_vec;
            r_hout   <= e_hout;
            r_has    <= e_has;
            r_last   <= e_last;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {PAD_W'(0), r_hout, r_vec, r_status};
    assign o_m_tuser  = r_has;
    assign o_m_tlast  = r_last;

`ifndef SYNTHESIS
    // vectors are never freed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ & $past(r_occ)) == $past(r_occ))
        else $error("occupancy flag cleared");

    // list streaming stays below the stored count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIG) |-> (r_idx < cnt_rd))
        else $error("trigger index past handler count");

    // a handler transfer always carries an ok status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[STATUS_W-1:0] == ST_OK))
        else $error("handler transfer with error status");

    // no new request while a list is streaming
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIG) |-> !o_s_tready)
        else $error("request taken during trigger");
`endif

endmodule

`default_nettype wire

// ===== rtl/ivalc_ram.sv =====
`default_nettype none

module ivalc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ivalc_search.sv =====
`default_nettype none

module ivalc_search #(
    parameter int NUM_VECTORS = ivalc_pkg::NUM_VECTORS_DEF
) (
    input  wire logic [NUM_VECTORS-1:0]         i_occ,
    input  wire logic [$clog2(NUM_VECTORS)-1:0] i_hint,
    output ivalc_pkg::t_search_res              o_res
);
    import ivalc_pkg::*;

    localparam int VIDX_W = $clog2(NUM_VECTORS);

    logic [NUM_VECTORS-1:0] free_all;
    logic [NUM_VECTORS-1:0] free_up;
    logic                   hit_up;
    logic                   hit_any;
    logic [VIDX_W-1:0]      idx_up;
    logic [VIDX_W-1:0]      idx_any;

    // First free vector at or above the hint, else first free from zero
    always_comb begin
        free_all = ~i_occ;
        for (int i = 0; i < NUM_VECTORS; i++) begin
            free_up[i] = free_all[i] && (VIDX_W'(i) >= i_hint);
        end
        hit_up  = 1'b0;
        hit_any = 1'b0;
        idx_up  = '0;
        idx_any = '0;
        for (int i = NUM_VECTORS - 1; i >= 0; i--) begin
            if (free_up[i]) begin
                hit_up = 1'b1;
                idx_up = VIDX_W'(i);
            end
            if (free_all[i]) begin
                hit_any = 1'b1;
                idx_any = VIDX_W'(i);
            end
        end
        o_res.found = hit_any;
        o_res.idx   = VEC_W'(hit_up ? idx_up : idx_any);
    end

endmodule

`default_nettype wire
